FILE: design/tslcg_pkg.sv
// Shared types, constants and the mixing table of the table-seeded random generator.
`default_nettype none

package tslcg_pkg;

  localparam int unsigned StateWidth = 32;
  localparam int unsigned DrawWidth  = 28;
  localparam int unsigned FracWidth  = 16;
  localparam int unsigned MixWidth   = 15;
  localparam int unsigned MixDepth   = 256;
  localparam int unsigned IdxWidth   = $clog2(MixDepth);
  localparam int unsigned FracDraws  = 3;

  localparam logic [StateWidth-1:0] MulConst = 32'd69069;

  typedef enum logic [1:0] {
    CMD_RESEED = 2'd0,
    CMD_NEXT   = 2'd1,
    CMD_RANGE  = 2'd2,
    CMD_FRAC   = 2'd3
  } tslcg_cmd_e;

  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_LOW,
    SEL_DRAW,
    SEL_FRAC,
    SEL_LOW_DRAW,
    SEL_LOW_REM
  } tslcg_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_DONE
  } tslcg_state_e;

  typedef struct packed {
    logic       load_in;
    logic       load_seed;
    logic       mul_en;
    logic       add_en;
    logic       div_start;
    logic       out_load;
    tslcg_sel_e res_sel;
  } tslcg_ctrl_t;

  typedef struct packed {
    logic range_one;
    logic range_zero;
    logic div_done;
  } tslcg_stat_t;

  localparam logic [MixWidth-1:0] MixWords [MixDepth] = '{
    28985, 27138, 26457, 9451, 17764, 10909, 28790, 8716,
    6361, 4853, 17798, 21977, 19643, 20662, 10834, 20103,
    27067, 28634, 18623, 25849, 8576, 26234, 23887, 18228,
    32587, 4836, 3306, 1811, 3035, 24559, 18399, 315,
    26766, 907, 24102, 12370, 9674, 2972, 10472, 16492,
    22683, 11529, 27968, 30406, 13213, 2319, 23620, 16823,
    10013, 23772, 21567, 1251, 19579, 20313, 18241, 30130,
    8402, 20807, 27354, 7169, 21211, 17293, 5410, 19223,
    10255, 22480, 27388, 9946, 15628, 24389, 17308, 2370,
    9530, 31683, 25927, 23567, 11694, 26397, 32602, 15031,
    18255, 17582, 1422, 28835, 23607, 12597, 20602, 10138,
    5212, 1252, 10074, 23166, 19823, 31667, 5902, 24630,
    18948, 14330, 14950, 8939, 23540, 21311, 22428, 22391,
    3583, 29004, 30498, 18714, 4278, 2437, 22430, 3439,
    28313, 23161, 25396, 13471, 19324, 15287, 2563, 18901,
    13103, 16867, 9714, 14322, 15197, 26889, 19372, 26241,
    31925, 14640, 11497, 8941, 10056, 6451, 28656, 10737,
    13874, 17356, 8281, 25937, 1661, 4850, 7448, 12744,
    21826, 5477, 10167, 16705, 26897, 8839, 30947, 27978,
    27283, 24685, 32298, 3525, 12398, 28726, 9475, 10208,
    617, 13467, 22287, 2376, 6097, 26312, 2974, 9114,
    21787, 28010, 4725, 15387, 3274, 10762, 31695, 17320,
    18324, 12441, 16801, 27376, 22464, 7500, 5666, 18144,
    15314, 31914, 31627, 6495, 5226, 31203, 2331, 4668,
    12650, 18275, 351, 7268, 31319, 30119, 7600, 2905,
    13826, 11343, 13053, 15583, 30055, 31093, 5067, 761,
    9685, 11070, 21369, 27155, 3663, 26542, 20169, 12161,
    15411, 30401, 7580, 31784, 8985, 29367, 20989, 14203,
    29694, 21167, 10337, 1706, 28578, 887, 3373, 19477,
    14382, 675, 7033, 15111, 26138, 12252, 30996, 21409,
    25678, 18555, 13256, 23316, 22407, 16727, 991, 9236,
    5373, 29402, 6117, 15241, 27715, 19291, 19888, 19847
  };

endpackage

`default_nettype wire

FILE: design/tslcg_rem.sv
// Iterative restoring remainder unit: one dividend bit per cycle.
`default_nettype none

module tslcg_rem (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [tslcg_pkg::DrawWidth-1:0]     dividend_i,
  input  wire logic [tslcg_pkg::StateWidth-1:0]    divisor_i,
  output logic                                     done_o,
  output logic [tslcg_pkg::StateWidth-1:0]         rem_o
);

  localparam int unsigned CntWidth = $clog2(tslcg_pkg::DrawWidth);
  localparam logic [CntWidth-1:0] LastStep = CntWidth'(tslcg_pkg::DrawWidth - 1);

  logic                                  busy_q, busy_d;
  logic                                  done_q, done_d;
  logic [CntWidth-1:0]                   cnt_q, cnt_d;
  logic [tslcg_pkg::DrawWidth-1:0]       dvd_q, dvd_d;
  logic [tslcg_pkg::StateWidth-1:0]      rem_q, rem_d;
  logic [tslcg_pkg::StateWidth:0]        trial;
  logic [tslcg_pkg::StateWidth:0]        divisor_ext;

  assign trial       = {rem_q, dvd_q[tslcg_pkg::DrawWidth-1]};
  assign divisor_ext = {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so a kept trial fits.
      if (trial >= divisor_ext) begin
        rem_d = tslcg_pkg::StateWidth'(trial - divisor_ext);
      end else begin
        rem_d = trial[tslcg_pkg::StateWidth-1:0];
      end
      dvd_d = {dvd_q[tslcg_pkg::DrawWidth-2:0], 1'b0};
      cnt_d = cnt_q + CntWidth'(1);
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: design/tslcg_dp.sv
// Datapath: generator state, multiply and table-add stages, bounds and result register.
`default_nettype none

module tslcg_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire tslcg_pkg::tslcg_ctrl_t             ctrl_i,
  output tslcg_pkg::tslcg_stat_t                  stat_o,
  input  wire logic [1:0]                         command_i,
  input  wire logic [31:0]                        seed_value_i,
  input  wire logic signed [31:0]                 low_bound_i,
  input  wire logic signed [31:0]                 high_bound_i,
  output logic signed [31:0]                      result_value_o
);

  localparam int unsigned W = tslcg_pkg::StateWidth;

  logic [W-1:0]                       gen_q, gen_d;
  logic [W-1:0]                       prod_q;
  logic [W-1:0]                       lo_q;
  logic [W-1:0]                       range_q;
  logic [tslcg_pkg::IdxWidth-1:0]     idx_q, idx_d;
  logic [W-1:0]                       res_q, res_d;
  logic [W-1:0]                       lo_u, hi_u;
  logic [W-1:0]                       adv_sum;
  logic [W-1:0]                       rem;
  logic                               div_done;

  assign lo_u = low_bound_i;
  assign hi_u = high_bound_i;

  // Reseed index: the seed alone, or seed plus both bounds for the other commands.
  always_comb begin
    if (tslcg_pkg::tslcg_cmd_e'(command_i) == tslcg_pkg::CMD_RESEED) begin
      idx_d = seed_value_i[tslcg_pkg::IdxWidth-1:0];
    end else begin
      idx_d = seed_value_i[tslcg_pkg::IdxWidth-1:0] + lo_u[tslcg_pkg::IdxWidth-1:0]
            + hi_u[tslcg_pkg::IdxWidth-1:0];
    end
  end

  assign adv_sum = prod_q + W'(tslcg_pkg::MixWords[prod_q[tslcg_pkg::IdxWidth-1:0]]) + W'(1);

  always_comb begin
    gen_d = gen_q;
    if (ctrl_i.load_seed) begin
      gen_d = W'(tslcg_pkg::MixWords[idx_q]);
    end else if (ctrl_i.add_en) begin
      gen_d = adv_sum;
    end
  end

  always_comb begin
    case (ctrl_i.res_sel)
      tslcg_pkg::SEL_ZERO:     res_d = '0;
      tslcg_pkg::SEL_LOW:      res_d = lo_q;
      tslcg_pkg::SEL_DRAW:     res_d = W'(gen_q[tslcg_pkg::DrawWidth-1:0]);
      tslcg_pkg::SEL_FRAC:     res_d = W'(gen_q[tslcg_pkg::FracWidth-1:0]);
      tslcg_pkg::SEL_LOW_DRAW: res_d = lo_q + W'(gen_q[tslcg_pkg::DrawWidth-1:0]);
      tslcg_pkg::SEL_LOW_REM:  res_d = lo_q + rem;
      default:                 res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else begin
      gen_q <= gen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      lo_q    <= lo_u;
      range_q <= hi_u - lo_u + W'(1);
      idx_q   <= idx_d;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= gen_q * tslcg_pkg::MulConst;
    end
    if (ctrl_i.out_load) begin
      res_q <= res_d;
    end
  end

  tslcg_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (adv_sum[tslcg_pkg::DrawWidth-1:0]),
    .divisor_i  (range_q),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  assign stat_o.range_one  = (range_q == W'(1));
  assign stat_o.range_zero = (range_q == '0);
  assign stat_o.div_done   = div_done;

  assign result_value_o = res_q;

endmodule

`default_nettype wire

FILE: design/tslcg_ctrl.sv
// Controller: sequences reseed, advance and remainder steps and owns the output handshake.
`default_nettype none

module tslcg_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              command_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  input  wire tslcg_pkg::tslcg_stat_t  stat_i,
  output tslcg_pkg::tslcg_ctrl_t       ctrl_o
);

  localparam logic [1:0] LastDraw = 2'(tslcg_pkg::FracDraws - 1);

  tslcg_pkg::tslcg_state_e state_q, state_d;
  tslcg_pkg::tslcg_cmd_e   cmd_q, cmd_d;
  tslcg_pkg::tslcg_sel_e   sel_q, sel_d;
  logic [1:0]              draw_cnt_q, draw_cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    sel_d      = sel_q;
    draw_cnt_d = draw_cnt_q;
    ctrl_o     = '0;
    ctrl_o.res_sel = sel_q;
    case (state_q)
      tslcg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load_in = 1'b1;
          cmd_d      = tslcg_pkg::tslcg_cmd_e'(command_i);
          draw_cnt_d = '0;
          if (tslcg_pkg::tslcg_cmd_e'(command_i) == tslcg_pkg::CMD_NEXT) begin
            state_d = tslcg_pkg::ST_MUL;
          end else begin
            state_d = tslcg_pkg::ST_SEED;
          end
        end
      end
      tslcg_pkg::ST_SEED: begin
        ctrl_o.load_seed = 1'b1;
        case (cmd_q)
          tslcg_pkg::CMD_RESEED: begin
            sel_d   = tslcg_pkg::SEL_ZERO;
            state_d = tslcg_pkg::ST_DONE;
          end
          tslcg_pkg::CMD_RANGE: begin
            if (stat_i.range_one) begin
              sel_d   = tslcg_pkg::SEL_LOW;
              state_d = tslcg_pkg::ST_DONE;
            end else begin
              state_d = tslcg_pkg::ST_MUL;
            end
          end
          default: state_d = tslcg_pkg::ST_MUL;
        endcase
      end
      tslcg_pkg::ST_MUL: begin
        ctrl_o.mul_en = 1'b1;
        state_d = tslcg_pkg::ST_ADD;
      end
      tslcg_pkg::ST_ADD: begin
        ctrl_o.add_en = 1'b1;
        case (cmd_q)
          tslcg_pkg::CMD_FRAC: begin
            if (draw_cnt_q == LastDraw) begin
              sel_d   = tslcg_pkg::SEL_FRAC;
              state_d = tslcg_pkg::ST_DONE;
            end else begin
              draw_cnt_d = draw_cnt_q + 2'd1;
              state_d    = tslcg_pkg::ST_MUL;
            end
          end
          tslcg_pkg::CMD_RANGE: begin
            if (stat_i.range_zero) begin
              sel_d   = tslcg_pkg::SEL_LOW_DRAW;
              state_d = tslcg_pkg::ST_DONE;
            end else begin
              ctrl_o.div_start = 1'b1;
              state_d = tslcg_pkg::ST_DIV;
            end
          end
          default: begin
            sel_d   = tslcg_pkg::SEL_DRAW;
            state_d = tslcg_pkg::ST_DONE;
          end
        endcase
      end
      tslcg_pkg::ST_DIV: begin
        if (stat_i.div_done) begin
          sel_d   = tslcg_pkg::SEL_LOW_REM;
          state_d = tslcg_pkg::ST_DONE;
        end
      end
      tslcg_pkg::ST_DONE: begin
        if (out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d = tslcg_pkg::ST_IDLE;
        end
      end
      default: state_d = tslcg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tslcg_pkg::ST_IDLE;
      cmd_q       <= tslcg_pkg::CMD_RESEED;
      sel_q       <= tslcg_pkg::SEL_ZERO;
      draw_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      sel_q       <= sel_d;
      draw_cnt_q  <= draw_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != tslcg_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // A new result never overwrites one that is still waiting to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while full");

  // A started division is always waited for in the division state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.div_start |=> (state_q == tslcg_pkg::ST_DIV))
    else $error("division started without waiting for it");

  // A result only appears after the finishing state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == tslcg_pkg::ST_DONE))
    else $error("result shown outside the finishing state");

  // The fraction command never makes more than three draws.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tslcg_pkg::ST_ADD && cmd_q == tslcg_pkg::CMD_FRAC) |-> (draw_cnt_q <= LastDraw))
    else $error("too many fraction draws");
`endif

endmodule

`default_nettype wire

FILE: design/table_seeded_lcg_random_core.sv
// Top level of the table-seeded linear congruential random generator.
`default_nettype none

// This core keeps a 32-bit generator state and serves one request at a time. In each
// advance the state is multiplied by 69069 into a product register, then one plus a
// word from a 256-entry constant table, picked by the product's low byte, is added to
// form the new state; the draw is its low 28 bits. A next-draw request makes one
// advance, a fraction request reseeds and then makes three, and a ranged-integer
// request reseeds, advances once and reduces the draw modulo the range with an
// iterative remainder unit that handles one of the 28 draw bits per cycle. A range of
// one returns the lower bound without a draw, and a range that wraps to zero returns
// the lower bound plus the raw draw. The input stalls while a request is being worked
// on; the result sits in an output register, so a new request is taken while the
// previous result still waits.
module table_seeded_lcg_random_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         command_i,
  input  wire logic [31:0]        seed_value_i,
  input  wire logic signed [31:0] low_bound_i,
  input  wire logic signed [31:0] high_bound_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      result_value_o
);

  // Commands from the controller to the datapath, and status back.
  tslcg_pkg::tslcg_ctrl_t ctrl;
  tslcg_pkg::tslcg_stat_t stat;

  tslcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  tslcg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .command_i      (command_i),
    .seed_value_i   (seed_value_i),
    .low_bound_i    (low_bound_i),
    .high_bound_i   (high_bound_i),
    .result_value_o (result_value_o)
  );

endmodule

`default_nettype wire
